// ----- rtl/ifbm_pkg.sv -----
// shared types, codes and constants of the idle frame budget monitor
package ifbm_pkg;

   // field widths
   localparam int TIME_W     = 24;
   localparam int BUDGET_W   = 23;
   localparam int ATTEMPT_W  = 24;
   localparam int IDLE_W     = 16;
   localparam int SPARE_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // register reset values and limits
   localparam logic [BUDGET_W-1:0]  FRAME_BUDGET_RST  = 23'd16667;
   localparam logic [ATTEMPT_W-1:0] ATTEMPT_BUDGET_RST = 24'd8000;
   localparam logic [IDLE_W-1:0]    REQ_IDLE_RST      = 16'd30;
   localparam logic [BUDGET_W-1:0]  MIN_FRAME_BUDGET  = 23'd1000;
   localparam logic [IDLE_W-1:0]    IDLE_MAX          = '1;
   localparam logic [SPARE_W-1:0]   SPARE_MAX         = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BUDGET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTEMPT_BUDGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_IDLE       = 2'd2;

   // request operation codes
   typedef enum logic {
      FUNC_RECORD  = 1'b0,
      FUNC_CONSUME = 1'b1
   } func_type;

   // one captured request
   typedef struct packed {
      func_type                  func;
      logic signed [TIME_W-1:0]  actual_interval_us;
      logic signed [TIME_W-1:0]  target_interval_us;
      logic signed [TIME_W-1:0]  render_us;
      logic signed [TIME_W-1:0]  swap_us;
      logic                      transition_active;
   } req_type;

   // configuration register set
   typedef struct packed {
      logic [BUDGET_W-1:0]  frame_budget_us;
      logic [ATTEMPT_W-1:0] attempt_budget_us;
      logic [IDLE_W-1:0]    required_idle_frames;
   } cfg_type;

   // budget state and the result of one update
   typedef struct packed {
      logic [IDLE_W-1:0]  idle_frame_count;
      logic [SPARE_W-1:0] spare_time_us;
   } state_type;

   typedef struct packed {
      state_type next_state;
      logic      attempt_ready;
   } upd_type;

endpackage

// ----- rtl/ifbm_update.sv -----
// next budget state and ready flag for one request
module ifbm_update (
   input  ifbm_pkg::req_type   req,
   input  ifbm_pkg::cfg_type   cfg,
   input  ifbm_pkg::state_type cur,
   output ifbm_pkg::upd_type   upd
);

   logic [ifbm_pkg::BUDGET_W-1:0]  budget_eff;
   logic [ifbm_pkg::BUDGET_W-1:0]  tgt;
   logic [ifbm_pkg::BUDGET_W-1:0]  act;
   logic [ifbm_pkg::BUDGET_W+3:0]  act_x10;
   logic [ifbm_pkg::BUDGET_W+3:0]  tgt_x11;
   logic                           late;
   logic [ifbm_pkg::BUDGET_W-1:0]  render_pos;
   logic [ifbm_pkg::BUDGET_W-1:0]  swap_pos;
   logic [ifbm_pkg::BUDGET_W:0]    used;
   logic                           busy;
   logic [ifbm_pkg::BUDGET_W-1:0]  slack;
   logic [ifbm_pkg::SPARE_W:0]     spare_sum;
   logic [ifbm_pkg::SPARE_W-1:0]   spare_next;
   logic [ifbm_pkg::IDLE_W-1:0]    idle_next;
   logic [ifbm_pkg::IDLE_W-1:0]    need_idle;
   logic                           ready;

   // target falls back to the clamped frame budget, actual falls back to the target
   assign budget_eff = (cfg.frame_budget_us < ifbm_pkg::MIN_FRAME_BUDGET)
                       ? ifbm_pkg::MIN_FRAME_BUDGET : cfg.frame_budget_us;
   assign tgt = (req.target_interval_us[ifbm_pkg::TIME_W-1] ||
                 (req.target_interval_us == '0))
                ? budget_eff : req.target_interval_us[ifbm_pkg::BUDGET_W-1:0];
   assign act = (req.actual_interval_us[ifbm_pkg::TIME_W-1] ||
                 (req.actual_interval_us == '0))
                ? tgt : req.actual_interval_us[ifbm_pkg::BUDGET_W-1:0];

   // late frame: 10 * actual > 11 * target, by shifts and adds
   assign act_x10 = ({4'b0, act} << 3) + ({4'b0, act} << 1);
   assign tgt_x11 = ({4'b0, tgt} << 3) + ({4'b0, tgt} << 1) + {4'b0, tgt};
   assign late    = act_x10 > tgt_x11;

   // render plus swap with negatives clamped
   assign render_pos = req.render_us[ifbm_pkg::TIME_W-1]
                       ? '0 : req.render_us[ifbm_pkg::BUDGET_W-1:0];
   assign swap_pos   = req.swap_us[ifbm_pkg::TIME_W-1]
                       ? '0 : req.swap_us[ifbm_pkg::BUDGET_W-1:0];
   assign used = {1'b0, render_pos} + {1'b0, swap_pos};
   assign busy = used >= {1'b0, tgt};

   // saturating growth of slack and idle count
   assign slack      = tgt - used[ifbm_pkg::BUDGET_W-1:0];
   assign spare_sum  = {1'b0, cur.spare_time_us}
                       + {{(ifbm_pkg::SPARE_W - ifbm_pkg::BUDGET_W + 1){1'b0}}, slack};
   assign spare_next = spare_sum[ifbm_pkg::SPARE_W]
                       ? ifbm_pkg::SPARE_MAX : spare_sum[ifbm_pkg::SPARE_W-1:0];
   assign idle_next  = (cur.idle_frame_count == ifbm_pkg::IDLE_MAX)
                       ? cur.idle_frame_count : cur.idle_frame_count + 1'b1;

   // thresholds, a zero idle requirement counts as one
   assign need_idle = (cfg.required_idle_frames == '0)
                      ? {{(ifbm_pkg::IDLE_W-1){1'b0}}, 1'b1} : cfg.required_idle_frames;
   assign ready = (idle_next >= need_idle) &&
                  (spare_next >= {{(ifbm_pkg::SPARE_W - ifbm_pkg::ATTEMPT_W){1'b0}},
                                  cfg.attempt_budget_us});

   // pick the outcome
   always_comb begin
      upd.next_state.idle_frame_count = '0;
      upd.next_state.spare_time_us    = '0;
      upd.attempt_ready               = 1'b0;
      if (req.func == ifbm_pkg::FUNC_RECORD) begin
         if (req.transition_active) begin
            upd.next_state = cur;
         end else if (!late && !busy) begin
            upd.next_state.idle_frame_count = idle_next;
            upd.next_state.spare_time_us    = spare_next;
            upd.attempt_ready               = ready;
         end
      end
   end

endmodule

// ----- rtl/idle_frame_budget_monitor_core.sv -----
// top level of the idle frame budget monitor
//
// Usage: one record request per displayed frame on the req_ channel carries
// the measured and target intervals, render and swap times and a transition
// flag; a consume request (req_func = 1) clears the budget after a background
// job is started. Each request gives exactly one response on the rsp_ channel,
// rsp_attempt_ready, high when the idle frame count and the spare time both
// meet their thresholds after that frame.
// The request register loads at the accepting edge and the response register,
// with the state update result, loads from it at the first edge on which the
// response register is free, which raises rsp_valid. Throughput is one
// request per cycle while rsp_ready keeps the response register moving, as the
// state update loop between the two registers is combinational.
// A stalled response (rsp_ready low) holds the response register; the request
// register then holds too and req_ready drops once both are full, so nothing
// is lost. The state only changes when a request moves into the response
// register.
// The csr_ port writes the frame budget, attempt budget and required idle
// frames at any edge with csr_wen high; write only while no request is in
// flight. Synchronous reset loads the register defaults, clears the idle count
// and spare time and empties both pipeline registers.
module idle_frame_budget_monitor_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_func,
   input  logic signed [ifbm_pkg::TIME_W-1:0]       req_actual_interval_us,
   input  logic signed [ifbm_pkg::TIME_W-1:0]       req_target_interval_us,
   input  logic signed [ifbm_pkg::TIME_W-1:0]       req_render_us,
   input  logic signed [ifbm_pkg::TIME_W-1:0]       req_swap_us,
   input  logic                                     req_transition_active,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_attempt_ready,
   input  logic                                     csr_wen,
   input  logic [ifbm_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ifbm_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   ifbm_pkg::cfg_type   cfg_ff;
   ifbm_pkg::cfg_type   cfg_in;
   ifbm_pkg::req_type   req_ff;
   ifbm_pkg::req_type   req_in;
   logic                req_valid_ff;
   logic                req_valid_in;
   ifbm_pkg::state_type state_ff;
   ifbm_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_ready_ff;
   logic                rsp_ready_in;
   ifbm_pkg::upd_type   upd;
   logic                advance;
   logic                req_take;

   // handshake control
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_attempt_ready = rsp_ready_ff;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            ifbm_pkg::CSR_FRAME_BUDGET: begin
               cfg_in.frame_budget_us = csr_wdata[ifbm_pkg::BUDGET_W-1:0];
            end
            ifbm_pkg::CSR_ATTEMPT_BUDGET: begin
               cfg_in.attempt_budget_us = csr_wdata[ifbm_pkg::ATTEMPT_W-1:0];
            end
            ifbm_pkg::CSR_REQ_IDLE: begin
               cfg_in.required_idle_frames = csr_wdata[ifbm_pkg::IDLE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // request register
   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_in.func               = ifbm_pkg::func_type'(req_func);
         req_in.actual_interval_us = req_actual_interval_us;
         req_in.target_interval_us = req_target_interval_us;
         req_in.render_us          = req_render_us;
         req_in.swap_us            = req_swap_us;
         req_in.transition_active  = req_transition_active;
         req_valid_in              = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   // state update between request and response registers
   ifbm_update u_update (
      .req (req_ff),
      .cfg (cfg_ff),
      .cur (state_ff),
      .upd (upd)
   );

   // response register and state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ready_in = rsp_ready_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
         if (req_valid_ff) begin
            state_in     = upd.next_state;
            rsp_ready_in = upd.attempt_ready;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_budget_us      <= ifbm_pkg::FRAME_BUDGET_RST;
         cfg_ff.attempt_budget_us    <= ifbm_pkg::ATTEMPT_BUDGET_RST;
         cfg_ff.required_idle_frames <= ifbm_pkg::REQ_IDLE_RST;
         req_valid_ff                <= 1'b0;
         rsp_valid_ff                <= 1'b0;
         state_ff                    <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ready_ff <= rsp_ready_in;
   end

   // a ready response implies at least one idle frame behind it
   a_ready_has_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready_ff |-> state_ff.idle_frame_count != '0)
      else $error("ready response with zero idle count");

   // slack only builds up together with idle frames
   a_spare_needs_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.spare_time_us != '0 |-> state_ff.idle_frame_count != '0)
      else $error("spare time without idle frames");

   // a consume request clears the budget
   a_consume_clears: assert property (@(posedge clock) disable iff (reset)
      advance && req_valid_ff && req_ff.func == ifbm_pkg::FUNC_CONSUME
      |=> state_ff == '0 && !rsp_ready_ff)
      else $error("consume did not clear budget");

   // state moves only when a request enters the response register
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !(advance && req_valid_ff) |=> $stable(state_ff))
      else $error("state changed without a request");

endmodule

// ----- tb/sv/idle_frame_budget_monitor_core_tb.sv -----
// self-checking testbench for the idle frame budget monitor core
module idle_frame_budget_monitor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_MAX       = 8388607;
   localparam int WATCHDOG_LIMIT = 4000;

   // clock, reset and block inputs, all known from the start
   logic                                      clock = 1'b0;
   logic                                      reset = 1'b1;
   logic                                      req_valid = 1'b0;
   logic                                      req_func = 1'b0;
   logic signed [ifbm_pkg::TIME_W-1:0]        req_actual_interval_us = '0;
   logic signed [ifbm_pkg::TIME_W-1:0]        req_target_interval_us = '0;
   logic signed [ifbm_pkg::TIME_W-1:0]        req_render_us = '0;
   logic signed [ifbm_pkg::TIME_W-1:0]        req_swap_us = '0;
   logic                                      req_transition_active = 1'b0;
   logic                                      rsp_ready = 1'b0;
   logic                                      csr_wen = 1'b0;
   logic [ifbm_pkg::CSR_IDX_W-1:0]            csr_index = '0;
   logic [ifbm_pkg::CSR_DATA_W-1:0]           csr_wdata = '0;
   logic                                      req_ready;
   logic                                      rsp_valid;
   logic                                      rsp_attempt_ready;

   // predicted register set and budget state
   ifbm_pkg::cfg_type                         model_cfg = '{ifbm_pkg::FRAME_BUDGET_RST,
                                                            ifbm_pkg::ATTEMPT_BUDGET_RST,
                                                            ifbm_pkg::REQ_IDLE_RST};
   logic [ifbm_pkg::IDLE_W-1:0]               idle_frames = '0;
   logic [ifbm_pkg::SPARE_W-1:0]              spare_us = '0;

   // request feed and expected ready flags
   ifbm_pkg::req_type                         frame_requests[$];
   logic                                      ready_expected[$];
   ifbm_pkg::req_type                         on_bus = '0;
   int                                        burst_left = 0;
   int                                        gap_left = 0;
   logic [15:0]                               stall_mask = '1;
   int                                        stall_phase = 0;
   int                                        idle_cycles = 0;
   int                                        failures = 0;

   idle_frame_budget_monitor_core uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_func               (req_func),
      .req_actual_interval_us (req_actual_interval_us),
      .req_target_interval_us (req_target_interval_us),
      .req_render_us          (req_render_us),
      .req_swap_us            (req_swap_us),
      .req_transition_active  (req_transition_active),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_attempt_ready      (rsp_attempt_ready),
      .csr_wen                (csr_wen),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // append a request to the feed
   task automatic queue_frame(input ifbm_pkg::req_type r);
      frame_requests = {frame_requests, r};
   endtask

   // append an expected ready flag
   task automatic queue_result(input logic flag);
      ready_expected = {ready_expected, flag};
   endtask

   // budget update for one accepted request, returns the ready flag
   function automatic logic next_attempt_ready(input ifbm_pkg::req_type r);
      longint                      act;
      longint                      tgt;
      longint                      used;
      longint unsigned             total;
      logic [ifbm_pkg::IDLE_W-1:0] need;
      act = longint'($signed(r.actual_interval_us));
      tgt = longint'($signed(r.target_interval_us));
      if (r.func == ifbm_pkg::FUNC_CONSUME) begin
         idle_frames = '0;
         spare_us = '0;
         return 1'b0;
      end
      if (r.transition_active)
         return 1'b0;
      if (tgt <= 0)
         tgt = (model_cfg.frame_budget_us < ifbm_pkg::MIN_FRAME_BUDGET)
               ? longint'(ifbm_pkg::MIN_FRAME_BUDGET) : longint'(model_cfg.frame_budget_us);
      if (act <= 0)
         act = tgt;
      // late frame
      if (act * 10 > tgt * 11) begin
         idle_frames = '0;
         spare_us = '0;
         return 1'b0;
      end
      used = 0;
      if ($signed(r.render_us) > 0)
         used = used + longint'($signed(r.render_us));
      if ($signed(r.swap_us) > 0)
         used = used + longint'($signed(r.swap_us));
      // frame time used up
      if (used >= tgt) begin
         idle_frames = '0;
         spare_us = '0;
         return 1'b0;
      end
      // idle frame: grow both, saturating
      if (idle_frames != ifbm_pkg::IDLE_MAX)
         idle_frames = idle_frames + 1'b1;
      total = {32'd0, spare_us} + 64'(tgt - used);
      spare_us = (total > {32'd0, ifbm_pkg::SPARE_MAX}) ? ifbm_pkg::SPARE_MAX
                                                         : total[ifbm_pkg::SPARE_W-1:0];
      need = (model_cfg.required_idle_frames == '0) ? 16'd1 : model_cfg.required_idle_frames;
      return (idle_frames >= need) && (spare_us >= model_cfg.attempt_budget_us);
   endfunction

   function automatic ifbm_pkg::req_type frame_req(
         input ifbm_pkg::func_type f,
         input logic signed [ifbm_pkg::TIME_W-1:0] act,
         input logic signed [ifbm_pkg::TIME_W-1:0] tgt,
         input logic signed [ifbm_pkg::TIME_W-1:0] rnd,
         input logic signed [ifbm_pkg::TIME_W-1:0] swp,
         input logic trn);
      ifbm_pkg::req_type r;
      r.func = f;
      r.actual_interval_us = act;
      r.target_interval_us = tgt;
      r.render_us = rnd;
      r.swap_us = swp;
      r.transition_active = trn;
      return r;
   endfunction

   // mostly idle frames; disturb percent of them late, used up, transition,
   // consume or plain noise
   function automatic ifbm_pkg::req_type make_frame(input int disturb);
      ifbm_pkg::req_type r;
      int      t;
      int      rnd;
      int      swp;
      int      hi;
      int      kind;
      r = '0;
      r.func = ifbm_pkg::FUNC_RECORD;
      if ($urandom_range(0, 9) == 0) begin
         r.target_interval_us = ifbm_pkg::TIME_W'(-$urandom_range(0, TIME_MAX + 1));
         t = (model_cfg.frame_budget_us < ifbm_pkg::MIN_FRAME_BUDGET)
             ? int'(ifbm_pkg::MIN_FRAME_BUDGET) : int'(model_cfg.frame_budget_us);
      end else begin
         t = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 999) : $urandom_range(1000, 40000);
         r.target_interval_us = ifbm_pkg::TIME_W'(t);
      end
      hi = (t * 11 / 10 > TIME_MAX) ? TIME_MAX : t * 11 / 10;
      if ($urandom_range(0, 9) == 0)
         r.actual_interval_us = ifbm_pkg::TIME_W'(-$urandom_range(0, TIME_MAX + 1));
      else
         r.actual_interval_us = ifbm_pkg::TIME_W'($urandom_range(t / 2, hi));
      rnd = $urandom_range(0, (t - 1) / 2);
      swp = $urandom_range(0, t - 1 - rnd);
      r.render_us = ($urandom_range(0, 9) == 0)
                    ? ifbm_pkg::TIME_W'(-$urandom_range(1, TIME_MAX + 1))
                    : ifbm_pkg::TIME_W'(rnd);
      r.swap_us = ($urandom_range(0, 9) == 0)
                  ? ifbm_pkg::TIME_W'(-$urandom_range(1, TIME_MAX + 1))
                  : ifbm_pkg::TIME_W'(swp);
      if ($urandom_range(0, 99) < disturb) begin
         kind = $urandom_range(0, 4);
         // late is impossible when 1.1 times target is past the field range
         if (kind == 0 && t * 11 / 10 >= TIME_MAX)
            kind = 1;
         case (kind)
            0: begin
               hi = (t * 3 > TIME_MAX) ? TIME_MAX : t * 3;
               r.actual_interval_us = ifbm_pkg::TIME_W'($urandom_range(t * 11 / 10 + 1, hi));
            end
            1: begin
               rnd = $urandom_range(0, t);
               swp = t - rnd + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 100));
               if (swp > TIME_MAX)
                  swp = TIME_MAX;
               r.render_us = ifbm_pkg::TIME_W'(rnd);
               r.swap_us = ifbm_pkg::TIME_W'(swp);
            end
            2: r.transition_active = 1'b1;
            3: begin
               r.func = ifbm_pkg::FUNC_CONSUME;
               r.transition_active = 1'($urandom_range(0, 1));
            end
            default: begin
               r.func = ifbm_pkg::func_type'(1'($urandom_range(0, 1)));
               r.actual_interval_us = ifbm_pkg::TIME_W'($urandom);
               r.target_interval_us = ifbm_pkg::TIME_W'($urandom);
               r.render_us = ifbm_pkg::TIME_W'($urandom);
               r.swap_us = ifbm_pkg::TIME_W'($urandom);
               r.transition_active = 1'($urandom_range(0, 1));
            end
         endcase
      end
      return r;
   endfunction

   task automatic add_frames(input int count, input int disturb);
      for (int i = 0; i < count; i++)
         queue_frame(make_frame(disturb));
   endtask

   // wait until every request is accepted and every response has come
   task automatic drain();
      @(negedge clock);
      while (frame_requests.size() != 0 || req_valid || ready_expected.size() != 0)
         @(negedge clock);
   endtask

   // write all three registers, block idle
   task automatic set_budgets(input logic [ifbm_pkg::CSR_DATA_W-1:0] fb,
                              input logic [ifbm_pkg::CSR_DATA_W-1:0] att,
                              input logic [ifbm_pkg::CSR_DATA_W-1:0] idle);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= ifbm_pkg::CSR_FRAME_BUDGET;
      csr_wdata <= fb;
      @(posedge clock);
      csr_index <= ifbm_pkg::CSR_ATTEMPT_BUDGET;
      csr_wdata <= att;
      @(posedge clock);
      csr_index <= ifbm_pkg::CSR_REQ_IDLE;
      csr_wdata <= idle;
      @(posedge clock);
      csr_wen <= 1'b0;
      model_cfg.frame_budget_us = fb[ifbm_pkg::BUDGET_W-1:0];
      model_cfg.attempt_budget_us = att[ifbm_pkg::ATTEMPT_W-1:0];
      model_cfg.required_idle_frames = idle[ifbm_pkg::IDLE_W-1:0];
      @(negedge clock);
   endtask

   // request driver: bursts with random gaps, payload held until accepted
   always @(posedge clock) begin : drive_p
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            queue_result(next_attempt_ready(on_bus));
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0 || frame_requests.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               on_bus = frame_requests.pop_front();
               req_valid <= 1'b1;
               req_func <= on_bus.func;
               req_actual_interval_us <= on_bus.actual_interval_us;
               req_target_interval_us <= on_bus.target_interval_us;
               req_render_us <= on_bus.render_us;
               req_swap_us <= on_bus.swap_us;
               req_transition_active <= on_bus.transition_active;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // response monitor and stall pattern
   always @(posedge clock) begin : check_p
      logic want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ready_expected.size() == 0) begin
               $display("%0t: unexpected response, expected none actual attempt_ready=%0b",
                        $time, rsp_attempt_ready);
               failures++;
            end else begin
               want = ready_expected.pop_front();
               if (rsp_attempt_ready !== want) begin
                  $display("%0t: attempt_ready mismatch, expected %0b actual %0b",
                           $time, want, rsp_attempt_ready);
                  failures++;
               end
            end
         end
         // new stall pattern each time the phase counter wraps: open, sparse or dense
         if (stall_phase == 0) begin
            case ($urandom_range(0, 2))
               0: stall_mask = '1;
               1: stall_mask = 16'($urandom) | 16'h0001;
               default: stall_mask = 16'($urandom | $urandom) | 16'h0001;
            endcase
         end
         rsp_ready <= stall_mask[stall_phase];
         stall_phase = (stall_phase + 1) % 16;
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin : watchdog_p
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wen)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // stimulus phases
   initial begin : stimulus_p
      logic [ifbm_pkg::CSR_DATA_W-1:0] fb;
      logic [ifbm_pkg::CSR_DATA_W-1:0] att;
      logic [ifbm_pkg::CSR_DATA_W-1:0] idle;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset register values
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 0, 0, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 24'sh800000, 24'sh800000, 24'sh800000,
                            24'sh800000, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 11001, 10000, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 11000, 10000, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 5000, 10000, 6000, 4000, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 5000, 10000, 5999, 4000, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 24'sh7FFFFF, 1, 0, 0, 1'b1));
      queue_frame(frame_req(ifbm_pkg::FUNC_CONSUME, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                            24'sh7FFFFF, 1'b1));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 0, 20000, 24'sh7FFFFF, 24'sh7FFFFF,
                            1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 24'sh7FFFFF, 1, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 1, 1, 24'sh800000, 24'sh800000, 1'b0));
      drain();
      add_frames(300, 3);
      drain();

      // frame budget below minimum, zero thresholds
      set_budgets(24'd0, 24'd0, 24'd0);
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 0, 0, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 1100, -5, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 1101, 0, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 0, 0, 999, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_CONSUME, 0, 0, 0, 0, 1'b0));
      queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 0, 0, 0, 0, 1'b0));
      add_frames(200, 20);
      drain();

      // slack saturation: largest fallback target, largest attempt budget
      set_budgets(24'h7FFFFF, 24'hFFFFFF, 24'd1);
      for (int i = 0; i < 600; i++)
         queue_frame(frame_req(ifbm_pkg::FUNC_RECORD, 24'(-$urandom_range(0, 100)),
                               24'(-$urandom_range(0, 100)),
                               24'(-$urandom_range(0, 100)), 0, 1'b0));
      drain();

      // largest idle requirement, never met in a short run
      set_budgets(24'd1000, 24'd0, 24'hFFFF);
      add_frames(40, 0);
      drain();

      // random register settings
      for (int p = 0; p < 4; p++) begin
         case ($urandom_range(0, 3))
            0: fb = 24'($urandom_range(0, 999));
            1: fb = 24'($urandom) & 24'h7FFFFF;
            default: fb = 24'($urandom_range(1000, 40000));
         endcase
         att = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000));
         idle = ($urandom_range(0, 3) == 0) ? 24'($urandom & 16'hFFFF)
                                            : 24'($urandom_range(0, 40));
         set_budgets(fb, att, idle);
         add_frames(190, 10);
         drain();
      end

      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- idle_frame_budget_monitor_core.f -----
rtl/ifbm_pkg.sv
rtl/ifbm_update.sv
rtl/idle_frame_budget_monitor_core.sv
tb/sv/idle_frame_budget_monitor_core_tb.sv
